// File: rtl/rbps_pkg.sv
// shared types, register codes and helpers for the rounded box pixel shader
`timescale 1ns / 1ps

package rbps_pkg;

    // limits of the box geometry
    localparam int MAX_RADIUS = 63;
    localparam int MAX_WIDTH  = 240;
    localparam int MAX_HEIGHT = 320;

    // widths of the configuration registers
    localparam int WIDTH_REG_W  = 8;
    localparam int HEIGHT_REG_W = 9;
    localparam int RADIUS_REG_W = 6;
    localparam int COLOR_REG_W  = 16;
    localparam int BORDER_REG_W = 6;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;

    // depth of the queue between classifier and shader
    localparam int QUEUE_DEPTH = 4;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_RADIUS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_RGB     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_RGB      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THICK    = 3'd5;

    // pixel classes
    localparam logic [1:0] CLASS_BLANK  = 2'd0;
    localparam logic [1:0] CLASS_BORDER = 2'd1;
    localparam logic [1:0] CLASS_FILL   = 2'd2;

    typedef struct packed {
        logic [7:0] column;
        logic [8:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [1:0]  pixel_class;
    } t_pix_out;

    // saturated configuration as seen by the datapath
    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  box_width;
        logic [HEIGHT_REG_W-1:0] box_height;
        logic [RADIUS_REG_W-1:0] radius;
        logic [BORDER_REG_W-1:0] edge_thick;
        logic [COLOR_REG_W-1:0]  inner_rgb;
        logic [COLOR_REG_W-1:0]  edge_rgb;
    } t_cfg;

    // pixel plus box test result, carried from classifier to shader
    typedef struct packed {
        t_pix_in pix;
        logic    inbox;
    } t_tag;

    // bits needed for the effective radius
    function automatic int rad_bits(input int max_r);
        return (max_r >= 63) ? RADIUS_REG_W : $clog2(max_r + 1);
    endfunction

endpackage

// File: rtl/rbps_front.sv
// classifier: box test, corner row offset and squared span radius
`timescale 1ns / 1ps

module rbps_front #(
    parameter int MAX_RADIUS = rbps_pkg::MAX_RADIUS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rbps_pkg::t_cfg          i_cfg,
    input  logic                    i_valid,
    input  rbps_pkg::t_pix_in       i_pix,
    output logic                    o_stall,
    input  logic                    i_full,
    output logic                    o_push,
    output rbps_pkg::t_tag          o_tag,
    output logic [2*rbps_pkg::rad_bits(MAX_RADIUS)-1:0] o_n
);

    localparam int RW = rbps_pkg::rad_bits(MAX_RADIUS);

    logic en;
    logic [RW-1:0] rad;
    logic [2*RW-1:0] rad_sq;
    logic inbox;
    logic [9:0] top_diff;
    logic [9:0] bot_sum;
    logic [9:0] bot_diff;
    logic [RW-1:0] off;
    logic [2*RW-1:0] off_sq;

    logic r_s1_valid;
    rbps_pkg::t_tag r_s1_tag;
    logic [RW-1:0] r_s1_off;
    logic r_s2_valid;
    rbps_pkg::t_tag r_s2_tag;
    logic [2*RW-1:0] r_s2_n;
    logic [2*RW-1:0] r_rsq;

    assign en = !(r_s2_valid && i_full);
    assign o_stall = !en;
    assign o_push = r_s2_valid && !i_full;
    assign o_tag = r_s2_tag;
    assign o_n = r_s2_n;

    // effective radius never exceeds the limit, so the low bits hold it
    assign rad = i_cfg.radius[RW-1:0];
    assign rad_sq = {{RW{1'b0}}, rad} * {{RW{1'b0}}, rad};

    always_comb begin
        inbox = (i_pix.column < i_cfg.box_width) && (i_pix.row < i_cfg.box_height);
        top_diff = 10'(rad) - 10'd1 - 10'(i_pix.row);
        bot_sum = 10'(i_pix.row) + 10'(rad);
        bot_diff = bot_sum - 10'(i_cfg.box_height);
        if (10'(i_pix.row) < 10'(rad)) begin
            off = top_diff[RW-1:0];
        end else if (bot_sum >= 10'(i_cfg.box_height)) begin
            off = bot_diff[RW-1:0];
        end else begin
            off = '0;
        end
    end

    assign off_sq = {{RW{1'b0}}, r_s1_off} * {{RW{1'b0}}, r_s1_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsq <= rad_sq;
        if (en) begin
            r_s1_tag.pix <= i_pix;
            r_s1_tag.inbox <= inbox;
            r_s1_off <= off;
            r_s2_tag <= r_s1_tag;
            r_s2_n <= r_rsq - off_sq;
        end
    end

endmodule

// File: rtl/rbps_queue.sv
// small register queue between classifier and shader
`timescale 1ns / 1ps

module rbps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rbps_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/rbps_back.sv
// shader: pipelined rounded square root, span limits and color select
`timescale 1ns / 1ps

module rbps_back #(
    parameter int MAX_RADIUS = rbps_pkg::MAX_RADIUS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rbps_pkg::t_cfg          i_cfg,
    input  logic                    i_empty,
    input  rbps_pkg::t_tag          i_tag,
    input  logic [2*rbps_pkg::rad_bits(MAX_RADIUS)-1:0] i_n,
    output logic                    o_pop,
    output logic                    o_valid,
    output rbps_pkg::t_pix_out      o_data,
    input  logic                    i_stall
);

    localparam int RW = rbps_pkg::rad_bits(MAX_RADIUS);
    // root of 4n carries one more bit, rounding comes from its lsb
    localparam int RB = RW + 1;

    logic en;

    logic            in_v   [RB];
    rbps_pkg::t_tag  in_tag [RB];
    logic [2*RB-1:0] in_m   [RB];
    logic [RB-1:0]   in_q   [RB];
    logic [RB:0]     in_rem [RB];
    logic [RB+2:0]   cur    [RB];
    logic [RB+2:0]   trial  [RB];
    logic [RB+2:0]   diff   [RB];
    logic            take   [RB];
    logic [RB-1:0]   n_q    [RB];
    logic [RB:0]     n_rem  [RB];

    logic            r_sv   [RB];
    rbps_pkg::t_tag  r_stag [RB];
    logic [2*RB-1:0] r_sm   [RB];
    logic [RB-1:0]   r_sq   [RB];
    logic [RB:0]     r_srem [RB];

    logic [RB:0] q_inc;
    logic [RB-1:0] d_full;
    logic [RW-1:0] rad;
    logic [RW-1:0] lx;

    logic r_p_valid;
    rbps_pkg::t_tag r_p_tag;
    logic [RW-1:0] r_p_lx;

    logic [10:0] col_e;
    logic [10:0] row_e;
    logic [10:0] lx_e;
    logic [10:0] bw_e;
    logic blank;
    logic border;
    rbps_pkg::t_pix_out pix_out;

    logic r_out_valid;
    rbps_pkg::t_pix_out r_out;

    assign en = !r_out_valid || !i_stall;
    assign o_pop = en && !i_empty;
    assign o_valid = r_out_valid;
    assign o_data = r_out;

    // one root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        localparam int P = RB - 1 - k;
        if (k == 0) begin : g_head
            assign in_v[k] = o_pop;
            assign in_tag[k] = i_tag;
            assign in_m[k] = {i_n, 2'b00};
            assign in_q[k] = '0;
            assign in_rem[k] = '0;
        end else begin : g_link
            assign in_v[k] = r_sv[k-1];
            assign in_tag[k] = r_stag[k-1];
            assign in_m[k] = r_sm[k-1];
            assign in_q[k] = r_sq[k-1];
            assign in_rem[k] = r_srem[k-1];
        end
        assign cur[k] = {in_rem[k], in_m[k][2*P+1 -: 2]};
        assign trial[k] = {1'b0, in_q[k], 2'b01};
        assign diff[k] = cur[k] - trial[k];
        assign take[k] = (cur[k] >= trial[k]);
        assign n_rem[k] = take[k] ? diff[k][RB:0] : cur[k][RB:0];
        assign n_q[k] = {in_q[k][RB-2:0], take[k]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RB; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < RB; k++) begin
                r_sv[k] <= in_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < RB; k++) begin
                r_stag[k] <= in_tag[k];
                r_sm[k] <= in_m[k];
                r_sq[k] <= n_q[k];
                r_srem[k] <= n_rem[k];
            end
        end
    end

    // d = round(sqrt(n)) = (floor(sqrt(4n)) + 1) / 2, left span edge r - d
    assign rad = i_cfg.radius[RW-1:0];
    assign q_inc = {1'b0, r_sq[RB-1]} + 1'b1;
    assign d_full = q_inc[RB:1];
    assign lx = rad - d_full[RW-1:0];

    // span and border tests with right edge folded into sums
    always_comb begin
        col_e = 11'(r_p_tag.pix.column);
        row_e = 11'(r_p_tag.pix.row);
        lx_e = 11'(r_p_lx);
        bw_e = 11'(i_cfg.edge_thick);
        blank = !r_p_tag.inbox || (col_e < lx_e) ||
                (col_e + lx_e >= 11'(i_cfg.box_width));
        border = (i_cfg.edge_thick != '0) &&
                 ((row_e < bw_e) ||
                  (row_e + bw_e >= 11'(i_cfg.box_height)) ||
                  (col_e < lx_e + bw_e) ||
                  (col_e + lx_e + bw_e >= 11'(i_cfg.box_width)));
        if (blank) begin
            pix_out.pixel_value = '0;
            pix_out.pixel_class = rbps_pkg::CLASS_BLANK;
        end else if (border) begin
            pix_out.pixel_value = {i_cfg.edge_rgb[7:0], i_cfg.edge_rgb[15:8]};
            pix_out.pixel_class = rbps_pkg::CLASS_BORDER;
        end else begin
            pix_out.pixel_value = {i_cfg.inner_rgb[7:0], i_cfg.inner_rgb[15:8]};
            pix_out.pixel_class = rbps_pkg::CLASS_FILL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_sv[RB-1];
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_tag <= r_stag[RB-1];
            r_p_lx <= lx;
            r_out <= pix_out;
        end
    end

endmodule

// File: rtl/rounded_box_pixel_shader.sv
// top level of the rounded box pixel shader
`timescale 1ns / 1ps

// channel   direction  signals                              item
// input     in         i_in_valid, i_in_data, o_in_stall    column, row
// output    out        o_out_valid, o_out_data, i_out_stall pixel_value, pixel_class
// config    in         i_cfg_we, i_cfg_index, i_cfg_data    one register write
//
// one item per clock sustained while i_out_stall stays low; an accepted item passes through the
// classifier stages, the queue, the rad_bits + 1 stages of the one-bit-per-stage square root,
// the span register and the output register before o_out_valid rises
// synchronous active-low reset clears all valid state and loads register defaults
// an output stall freezes only the shader; the classifier keeps taking items
// until the four-entry queue and its own last stage are full, then raises o_in_stall

module rounded_box_pixel_shader #(
    parameter int MAX_RADIUS = rbps_pkg::MAX_RADIUS,
    parameter int MAX_WIDTH  = rbps_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = rbps_pkg::MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  rbps_pkg::t_pix_in                   i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output rbps_pkg::t_pix_out                  o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [rbps_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [rbps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int RW = rbps_pkg::rad_bits(MAX_RADIUS);
    localparam int QW = $bits(rbps_pkg::t_tag) + 2 * RW;
    // saturation limits, clipped to what the register widths can hold
    localparam int SAT_W = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
    localparam int SAT_H = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int SAT_R = (MAX_RADIUS > 63) ? 63 : MAX_RADIUS;

    // configuration registers
    logic [7:0]  r_box_width;
    logic [8:0]  r_box_height;
    logic [5:0]  r_corner_radius;
    logic [15:0] r_inner_rgb;
    logic [15:0] r_edge_rgb;
    logic [5:0]  r_edge_thick;

    rbps_pkg::t_cfg cfg;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    rbps_pkg::t_tag f_tag;
    logic [2*RW-1:0] f_n;
    logic [QW-1:0] q_out;
    rbps_pkg::t_tag b_tag;
    logic [2*RW-1:0] b_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width <= 8'd228;
            r_box_height <= 9'd31;
            r_corner_radius <= 6'd6;
            r_inner_rgb <= '0;
            r_edge_rgb <= '0;
            r_edge_thick <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rbps_pkg::REG_BOX_WIDTH:     r_box_width <= i_cfg_data[7:0];
                rbps_pkg::REG_BOX_HEIGHT:    r_box_height <= i_cfg_data[8:0];
                rbps_pkg::REG_CORNER_RADIUS: r_corner_radius <= i_cfg_data[5:0];
                rbps_pkg::REG_INNER_RGB:     r_inner_rgb <= i_cfg_data;
                rbps_pkg::REG_EDGE_RGB:      r_edge_rgb <= i_cfg_data;
                rbps_pkg::REG_EDGE_THICK:    r_edge_thick <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // clamp geometry to the configured limits before use
    always_comb begin
        cfg.box_width = (r_box_width > 8'(SAT_W)) ? 8'(SAT_W) : r_box_width;
        cfg.box_height = (r_box_height > 9'(SAT_H)) ? 9'(SAT_H) : r_box_height;
        cfg.radius = (r_corner_radius > 6'(SAT_R)) ? 6'(SAT_R) : r_corner_radius;
        cfg.edge_thick = r_edge_thick;
        cfg.inner_rgb = r_inner_rgb;
        cfg.edge_rgb = r_edge_rgb;
    end

    // classifier: box test, corner offset, r*r - offset*offset
    rbps_front #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(cfg),
        .i_valid(i_in_valid),
        .i_pix(i_in_data),
        .o_stall(o_in_stall),
        .i_full(q_full),
        .o_push(q_push),
        .o_tag(f_tag),
        .o_n(f_n)
    );

    // decouples the two halves so an output stall does not reach the input at once
    rbps_queue #(
        .WIDTH(QW),
        .DEPTH(rbps_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(q_push),
        .i_data({f_tag, f_n}),
        .i_pop(q_pop),
        .o_data(q_out),
        .o_full(q_full),
        .o_empty(q_empty)
    );

    assign b_tag = q_out[QW-1:2*RW];
    assign b_n = q_out[2*RW-1:0];

    // shader: span half-width by square root, then class and color
    rbps_back #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(cfg),
        .i_empty(q_empty),
        .i_tag(b_tag),
        .i_n(b_n),
        .o_pop(q_pop),
        .o_valid(o_out_valid),
        .o_data(o_out_data),
        .i_stall(i_out_stall)
    );

endmodule

// File: rtl/rbps_checker.sv
// port-level checks for the rounded box pixel shader, bound to the top level
`timescale 1ns / 1ps

module rbps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input rbps_pkg::t_pix_in                i_in_data,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input rbps_pkg::t_pix_out               o_out_data,
    input logic                             i_out_stall,
    input logic                             i_cfg_we,
    input logic [rbps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input logic [rbps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // a stalled result stays and holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed under stall");

    // blank pixels carry no color
    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pixel_class == rbps_pkg::CLASS_BLANK
        |-> o_out_data.pixel_value == '0)
        else $error("blank pixel with nonzero value");

    // class code 3 is never produced
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pixel_class != 2'd3)
        else $error("unused pixel class");

    // reset empties the pipeline and frees the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state survived reset");

endmodule

bind rounded_box_pixel_shader rbps_checker u_rbps_checker (.*);

// File: tb/rounded_box_pixel_shader_tb.sv
// self-checking testbench for the rounded box pixel shader
`timescale 1ns / 1ps

module rounded_box_pixel_shader_tb;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // every block input starts from a known value
    logic                             i_in_valid  = 1'b0;
    rbps_pkg::t_pix_in                i_in_data   = '0;
    logic                             i_out_stall = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [rbps_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [rbps_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    rbps_pkg::t_pix_out               o_out_data;

    rounded_box_pixel_shader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // settle time after every pending pixel has come back; leave margin
    localparam int SETTLE_CYCLES = 30;

    // shadow copy of the register file, reset values as the block loads them
    logic [7:0]  box_w_reg    = 8'd228;
    logic [8:0]  box_h_reg    = 9'd31;
    logic [5:0]  radius_reg   = 6'd6;
    logic [15:0] fill_reg     = 16'h0000;
    logic [15:0] border_reg   = 16'h0000;
    logic [5:0]  border_w_reg = 6'd0;

    // pixels accepted by the block whose color has not come back yet
    rbps_pkg::t_pix_out pending_pixels[$];
    int                 mismatch_count = 0;

    // idling controls for each side, plus the long receiver hold-off
    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    int hold_cycles = 0;

    // expected color and class of one pixel under the shadow registers
    function automatic rbps_pkg::t_pix_out shade_pixel(input logic [7:0] col,
                                                       input logic [8:0] row);
        int                 px, py, w, h, r, bw, off, d, lx, rx, n, s;
        rbps_pkg::t_pix_out res;
        px  = int'(col);
        py  = int'(row);
        w   = (int'(box_w_reg) > rbps_pkg::MAX_WIDTH) ? rbps_pkg::MAX_WIDTH : int'(box_w_reg);
        h   = (int'(box_h_reg) > rbps_pkg::MAX_HEIGHT) ? rbps_pkg::MAX_HEIGHT
                                                       : int'(box_h_reg);
        r   = (int'(radius_reg) > rbps_pkg::MAX_RADIUS) ? rbps_pkg::MAX_RADIUS
                                                        : int'(radius_reg);
        bw  = int'(border_w_reg);
        res = '{pixel_value: 16'h0000, pixel_class: rbps_pkg::CLASS_BLANK};
        if (px < w && py < h) begin
            off = 0;
            if (py < r) begin
                off = r - 1 - py;
            end else if (py >= h - r) begin
                off = py - (h - r);
            end
            d = r;
            if (off > 0) begin
                // integer square root, then round to nearest
                n = r * r - off * off;
                s = 0;
                for (int b = 7; b >= 0; b--) begin
                    if ((s | (1 << b)) * (s | (1 << b)) <= n) s = s | (1 << b);
                end
                if (n > s * s + s) s = s + 1;
                d = s;
            end
            lx = r - d;
            rx = w - 1 - lx;
            // span limits are signed: a radius beyond the box can empty the span
            if (px < lx || px > rx) begin
                res.pixel_class = rbps_pkg::CLASS_BLANK;
            end else if (bw > 0 && (py < bw || py >= h - bw ||
                                    px < lx + bw || px > rx - bw)) begin
                res.pixel_value = {border_reg[7:0], border_reg[15:8]};
                res.pixel_class = rbps_pkg::CLASS_BORDER;
            end else begin
                res.pixel_value = {fill_reg[7:0], fill_reg[15:8]};
                res.pixel_class = rbps_pkg::CLASS_FILL;
            end
        end
        return res;
    endfunction

    // offer one pixel, with random idle cycles ahead of it, and wait for accept
    task automatic send_pixel(input logic [7:0] col, input logic [8:0] row);
        rbps_pkg::t_pix_out want;
        while (in_idle_on && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        want = shade_pixel(col, row);
        i_in_valid <= 1'b1;
        i_in_data  <= '{column: col, row: row};
        do @(posedge i_clk); while (o_in_stall);
        pending_pixels.push_back(want);
    endtask

    // stop offering and let every pending pixel come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; the caller lowers the write enable after the last one
    task automatic write_reg(input logic [rbps_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // rewrite the whole register file while the block is idle
    task automatic set_box(input logic [7:0] w, input logic [8:0] h, input logic [5:0] r,
                           input logic [15:0] fill, input logic [15:0] border,
                           input logic [5:0] bw);
        wait_drained();
        write_reg(rbps_pkg::REG_BOX_WIDTH,     {8'd0, w});
        write_reg(rbps_pkg::REG_BOX_HEIGHT,    {7'd0, h});
        write_reg(rbps_pkg::REG_CORNER_RADIUS, {10'd0, r});
        write_reg(rbps_pkg::REG_INNER_RGB,     fill);
        write_reg(rbps_pkg::REG_EDGE_RGB,      border);
        write_reg(rbps_pkg::REG_EDGE_THICK,    {10'd0, bw});
        i_cfg_we     <= 1'b0;
        box_w_reg    = w;
        box_h_reg    = h;
        radius_reg   = r;
        fill_reg     = fill;
        border_reg   = border;
        border_w_reg = bw;
    endtask

    // registers as loaded by reset: colors are zero so only the class tells
    task automatic test_reset_defaults();
        send_pixel(8'd0,   9'd0);
        send_pixel(8'd6,   9'd15);
        send_pixel(8'd227, 9'd30);
        send_pixel(8'd228, 9'd0);
    endtask

    // extremes of coordinates and registers, no idling on either side
    task automatic test_corner_cases();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        // largest legal box, largest radius, thin border
        set_box(8'd240, 9'd320, 6'd63, 16'h12F4, 16'hA50F, 6'd5);
        send_pixel(8'd0,   9'd0);
        send_pixel(8'd63,  9'd0);
        send_pixel(8'd120, 9'd160);
        send_pixel(8'd239, 9'd160);
        send_pixel(8'd239, 9'd319);
        send_pixel(8'd5,   9'd100);
        send_pixel(8'd255, 9'd511);
        // oversized width and height get clamped, square corners, widest border
        set_box(8'd255, 9'd511, 6'd0, 16'hFFFF, 16'h0000, 6'd63);
        send_pixel(8'd239, 9'd319);
        send_pixel(8'd240, 9'd0);
        send_pixel(8'd0,   9'd319);
        send_pixel(8'd128, 9'd256);
        // zero-sized box: nothing is inside
        set_box(8'd0, 9'd0, 6'd6, 16'hFFFF, 16'hFFFF, 6'd1);
        send_pixel(8'd0,   9'd0);
        send_pixel(8'd255, 9'd511);
        // radius larger than the box
        set_box(8'd10, 9'd8, 6'd63, 16'h5A5A, 16'hC3C3, 6'd1);
        send_pixel(8'd0, 9'd0);
        send_pixel(8'd5, 9'd4);
        send_pixel(8'd9, 9'd7);
        // rounded corners with no border at all
        set_box(8'd20, 9'd20, 6'd10, 16'h0001, 16'h8000, 6'd0);
        send_pixel(8'd0,  9'd0);
        send_pixel(8'd10, 9'd0);
        send_pixel(8'd9,  9'd10);
        send_pixel(8'd19, 9'd19);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // several register settings, each followed by a burst of random pixels
    task automatic test_random_boxes();
        logic [7:0] w;
        logic [8:0] h;
        logic [5:0] r, bw;
        logic [7:0] col;
        logic [8:0] row;
        int         w_eff, h_eff, reach_x, reach_y, sel;
        for (int phase = 0; phase < 8; phase++) begin
            w  = 8'($urandom_range(255));
            h  = 9'($urandom_range(511));
            r  = 6'($urandom_range(63));
            bw = 6'($urandom_range(63));
            case (phase)
                0: begin
                    w  = 8'($urandom_range(240, 16));
                    h  = 9'($urandom_range(320, 16));
                    r  = 6'($urandom_range(20));
                    bw = 6'($urandom_range(6));
                end
                1: begin
                    w  = 8'd240;
                    h  = 9'd320;
                    r  = 6'd63;
                    bw = 6'd63;
                end
                2: begin
                    w  = 8'd255;
                    h  = 9'd511;
                    r  = 6'd0;
                    bw = 6'd0;
                end
                3: begin
                    w  = 8'($urandom_range(16, 1));
                    h  = 9'($urandom_range(16, 1));
                    bw = 6'($urandom_range(8));
                end
                5: begin
                    w  = 8'd1;
                    h  = 9'($urandom_range(320, 1));
                    r  = 6'($urandom_range(3));
                    bw = 6'd1;
                end
                6: begin
                    w  = 8'($urandom_range(240, 100));
                    h  = 9'($urandom_range(320, 100));
                    r  = 6'($urandom_range(63, 30));
                    bw = 6'($urandom_range(20, 1));
                end
                default: begin
                end
            endcase
            set_box(w, h, r, 16'($urandom_range(65535)), 16'($urandom_range(65535)), bw);
            // one whole phase runs without any idling
            in_idle_on  = (phase != 1);
            out_idle_on = (phase != 1);
            w_eff   = (int'(w) > rbps_pkg::MAX_WIDTH)  ? rbps_pkg::MAX_WIDTH  : int'(w);
            h_eff   = (int'(h) > rbps_pkg::MAX_HEIGHT) ? rbps_pkg::MAX_HEIGHT : int'(h);
            reach_x = (int'(r) + int'(bw) < w_eff) ? int'(r) + int'(bw) : w_eff - 1;
            reach_y = (int'(r) + int'(bw) < h_eff) ? int'(r) + int'(bw) : h_eff - 1;
            for (int k = 0; k < 240; k++) begin
                sel = int'($urandom_range(99));
                if (sel < 20 || w_eff == 0 || h_eff == 0) begin
                    // anywhere, including beyond the box
                    col = 8'($urandom_range(255));
                    row = 9'($urandom_range(511));
                end else if (sel < 55) begin
                    // close to a corner, where span edges and border bands meet
                    col = $urandom_range(1) ? 8'($urandom_range(reach_x))
                                            : 8'(w_eff - 1 - int'($urandom_range(reach_x)));
                    row = $urandom_range(1) ? 9'($urandom_range(reach_y))
                                            : 9'(h_eff - 1 - int'($urandom_range(reach_y)));
                end else begin
                    col = 8'($urandom_range(w_eff - 1));
                    row = 9'($urandom_range(h_eff - 1));
                end
                send_pixel(col, row);
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // receiver holds off long enough that the queue fills and the input stalls
    task automatic test_output_hold();
        set_box(8'd64, 9'd48, 6'd12, 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 6'd3);
        in_idle_on  = 1'b0;
        hold_cycles = 80;
        for (int k = 0; k < 40; k++) begin
            send_pixel(8'($urandom_range(79)), 9'($urandom_range(59)));
        end
        in_idle_on = 1'b1;
    endtask

    // receiver side: random stalls, or a counted hold-off when one is asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end else begin
                i_out_stall <= out_idle_on && ($urandom_range(99) < 18);
            end
        end
    end

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        end
    endtask

    // compare each delivered item with the oldest pending pixel
    always @(posedge i_clk) begin
        rbps_pkg::t_pix_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                note_mismatch("unexpected item, value", 0, int'(o_out_data.pixel_value));
            end else begin
                want = pending_pixels.pop_front();
                if (o_out_data.pixel_value !== want.pixel_value) begin
                    note_mismatch("pixel_value", int'(want.pixel_value),
                                  int'(o_out_data.pixel_value));
                end
                if (o_out_data.pixel_class !== want.pixel_class) begin
                    note_mismatch("pixel_class", int'(want.pixel_class),
                                  int'(o_out_data.pixel_class));
                end
            end
        end
    end

    // main sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_corner_cases();
        test_output_hold();
        test_random_boxes();
        wait_drained();
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
